// ===== rtl/fadl_pkg.sv =====
`default_nettype none
package fadl_pkg;

	localparam int MAX_FRAMES_DEF   = 1024;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF  = 24;

	// register field widths
	localparam int LEN_W   = 11;
	localparam int FRAC_W  = 16;
	localparam int CHCNT_W = 4;
	localparam int DATA_W  = 16;
	localparam int INDEX_W = 2;

	typedef enum logic [INDEX_W-1:0] {
		CFG_RING_LEN,
		CFG_DELAY_WHOLE,
		CFG_DELAY_FRAC,
		CFG_CHANNEL_COUNT
	} cfg_idx_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ring_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/fadl_ring.sv =====
`default_nettype none
module fadl_ring #(
	parameter int DEPTH = fadl_pkg::MAX_FRAMES_DEF * fadl_pkg::MAX_CHANNELS_DEF,
	parameter int SB    = fadl_pkg::SAMPLE_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fadl_pkg::ring_ctrl_t ctrl,
	input  wire logic [AW-1:0]      rd0_addr,
	input  wire logic [AW-1:0]      rd1_addr,
	input  wire logic [AW-1:0]      wr_addr,
	input  wire logic [SB-1:0]      wr_data,
	output logic                    clearing,
	output logic [SB-1:0]           rd0_data,
	output logic [SB-1:0]           rd1_data
);

	logic [SB-1:0] mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic [SB-1:0] rd0_s1;
	logic [SB-1:0] rd1_s1;
	logic          wen;
	logic [AW-1:0] waddr;
	logic [SB-1:0] wdata;

	// zero every entry once after reset, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign wen   = clearing_q | ctrl.wr_en;
	assign waddr = clearing_q ? clr_addr_q : wr_addr;
	assign wdata = clearing_q ? '0 : wr_data;

	// reads see the contents before this cycle's write
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ctrl.rd_en) begin
			rd0_s1 <= mem[rd0_addr];
			rd1_s1 <= mem[rd1_addr];
		end
	end

	assign clearing = clearing_q;
	assign rd0_data = rd0_s1;
	assign rd1_data = rd1_s1;

endmodule
`default_nettype wire

// ===== rtl/fractional_audio_delay_line.sv =====
`default_nettype none
// Fractional delay line for interleaved multichannel audio with linear
// interpolation between two taps of the ring store. One sample is accepted
// per cycle while in_ready is high, and in_ready drops while out_ready holds
// back a result; the sample passes the ring read register and the output
// register before it shows on out_valid. The ring store gives both taps from
// two read ports while the new sample is written through a third in the same
// cycle. After reset in_ready stays low while the store is cleared one entry
// per cycle. After a write of ring_len, in_ready stays low while the frame
// position is reduced modulo the new ring length.
// Configuration writes are taken at any time but belong to idle periods.
module fractional_audio_delay_line #(
	parameter int MAX_FRAMES   = fadl_pkg::MAX_FRAMES_DEF,
	parameter int MAX_CHANNELS = fadl_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = fadl_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fadl_pkg::INDEX_W-1:0]  cfg_index,
	input  wire logic [fadl_pkg::DATA_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic                               frame_end
);

	localparam int SB    = SAMPLE_BITS;
	localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(MAX_FRAMES);
	localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int LW    = fadl_pkg::LEN_W;
	localparam int XW    = ((PW > LW) ? PW : LW) + 1;
	localparam int NCW   = $clog2(PW + 1);
	localparam int FW    = fadl_pkg::FRAC_W;

	logic [LW-1:0]                ring_len_q;
	logic [LW-1:0]                delay_whole_q;
	logic [FW-1:0]                delay_frac_q;
	logic [fadl_pkg::CHCNT_W-1:0] channel_count_q;

	logic [PW-1:0]  pos_q;
	logic [CHW-1:0] ch_q;

	logic [NCW-1:0] norm_cnt_q;
	logic [XW-1:0]  rem_q;
	logic [PW-1:0]  sh_q;
	logic [XW-1:0]  rem_shift;
	logic [XW-1:0]  rem_next;

	logic [XW-1:0]  len_eff;
	logic [XW-1:0]  dly_eff;
	logic [XW-1:0]  pos_x;
	logic [XW-1:0]  tap_sum;
	logic [XW-1:0]  f0;
	logic [XW-1:0]  f1;
	logic [CHW-1:0] chans_m1;
	logic           last;
	logic [CHW-1:0] ch_eff;
	logic [AW-1:0]  rd0_addr;
	logic [AW-1:0]  rd1_addr;
	logic [AW-1:0]  wr_addr;

	logic           accept;
	logic           adv_out;
	logic           clearing;
	fadl_pkg::ring_ctrl_t ring_ctrl;
	logic [SB-1:0]  rd0_data;
	logic [SB-1:0]  rd1_data;

	logic          v_s1;
	logic          last_s1;
	logic [FW-1:0] frac_s1;

	logic signed [SB-1:0]   d0;
	logic signed [SB-1:0]   d1;
	logic signed [SB:0]     diff;
	logic signed [SB+17:0]  prod;
	logic signed [SB+1:0]   q_term;
	logic signed [SB+1:0]   y_full;

	logic                 out_valid_q;
	logic signed [SB-1:0] out_sample_q;
	logic                 frame_end_q;

	// effective register values after clamping
	always_comb begin
		if (ring_len_q == '0) begin
			len_eff = XW'(1);
		end else if (32'(ring_len_q) > MAX_FRAMES) begin
			len_eff = XW'(MAX_FRAMES);
		end else begin
			len_eff = XW'(ring_len_q);
		end
		if (delay_whole_q == '0) begin
			dly_eff = XW'(1);
		end else if (XW'(delay_whole_q) > len_eff) begin
			dly_eff = len_eff;
		end else begin
			dly_eff = XW'(delay_whole_q);
		end
		if (channel_count_q == '0) begin
			chans_m1 = '0;
		end else if (32'(channel_count_q) > MAX_CHANNELS) begin
			chans_m1 = CHW'(MAX_CHANNELS - 1);
		end else begin
			chans_m1 = CHW'(channel_count_q - 1'b1);
		end
	end

	// pos is below len, so one conditional subtract wraps the tap
	always_comb begin
		pos_x   = XW'(pos_q);
		tap_sum = pos_x + len_eff - dly_eff;
		f0      = (tap_sum >= len_eff) ? tap_sum - len_eff : tap_sum;
		f1      = (f0 + 1'b1 == len_eff) ? '0 : f0 + 1'b1;
		last    = (ch_q >= chans_m1);
		ch_eff  = last ? chans_m1 : ch_q;
	end

	assign rd0_addr = AW'(AW'(f0) * AW'(MAX_CHANNELS)) + AW'(ch_eff);
	assign rd1_addr = AW'(AW'(f1) * AW'(MAX_CHANNELS)) + AW'(ch_eff);
	assign wr_addr  = AW'(AW'(pos_q) * AW'(MAX_CHANNELS)) + AW'(ch_eff);

	assign adv_out  = !out_valid_q || out_ready;
	assign in_ready = !clearing && (norm_cnt_q == '0) && (!v_s1 || adv_out);
	assign accept   = in_valid && in_ready;

	assign ring_ctrl.rd_en = accept;
	assign ring_ctrl.wr_en = accept;

	fadl_ring #(
		.DEPTH (DEPTH),
		.SB    (SB)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ring_ctrl),
		.rd0_addr (rd0_addr),
		.rd1_addr (rd1_addr),
		.wr_addr  (wr_addr),
		.wr_data  (in_sample),
		.clearing (clearing),
		.rd0_data (rd0_data),
		.rd1_data (rd1_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_len_q      <= LW'(1);
			delay_whole_q   <= LW'(1);
			delay_frac_q    <= '0;
			channel_count_q <= fadl_pkg::CHCNT_W'(1);
		end else if (cfg_we) begin
			unique case (fadl_pkg::cfg_idx_t'(cfg_index))
				fadl_pkg::CFG_RING_LEN:      ring_len_q      <= cfg_data[LW-1:0];
				fadl_pkg::CFG_DELAY_WHOLE:   delay_whole_q   <= cfg_data[LW-1:0];
				fadl_pkg::CFG_DELAY_FRAC:    delay_frac_q    <= cfg_data[FW-1:0];
				fadl_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[fadl_pkg::CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring remainder, one position bit per cycle
	always_comb begin
		rem_shift = {rem_q[XW-2:0], sh_q[PW-1]};
		rem_next  = (rem_shift >= len_eff) ? rem_shift - len_eff : rem_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ch_q       <= '0;
			norm_cnt_q <= '0;
			rem_q      <= '0;
			sh_q       <= '0;
		end else if (cfg_we && fadl_pkg::cfg_idx_t'(cfg_index) == fadl_pkg::CFG_RING_LEN) begin
			norm_cnt_q <= NCW'(PW);
			rem_q      <= '0;
			sh_q       <= pos_q;
		end else if (norm_cnt_q != '0) begin
			norm_cnt_q <= norm_cnt_q - 1'b1;
			rem_q      <= rem_next;
			sh_q       <= sh_q << 1;
			if (norm_cnt_q == NCW'(1)) begin
				pos_q <= PW'(rem_next);
			end
		end else if (accept) begin
			if (last) begin
				ch_q  <= '0;
				pos_q <= (pos_x + 1'b1 == len_eff) ? '0 : pos_q + 1'b1;
			end else begin
				ch_q <= ch_eff + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || adv_out) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
			frac_s1 <= delay_frac_q;
		end
	end

	// d0 + floor((d1 - d0) * frac / 2^16), arithmetic shift floors
	always_comb begin
		d0     = $signed(rd0_data);
		d1     = $signed(rd1_data);
		diff   = (SB+1)'(d1) - (SB+1)'(d0);
		prod   = diff * $signed({1'b0, frac_s1});
		q_term = prod[SB+17:16];
		y_full = (SB+2)'(d0) + q_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s1) begin
			out_sample_q <= y_full[SB-1:0];
			frame_end_q  <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign frame_end  = frame_end_q;

endmodule
`default_nettype wire

// ===== rtl/fadl_checker.sv =====
`default_nettype none
module fadl_checker #(
	parameter int SAMPLE_BITS = fadl_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_we,
	input wire logic [fadl_pkg::INDEX_W-1:0]  cfg_index,
	input wire logic [fadl_pkg::DATA_W-1:0]   cfg_data,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic signed [SAMPLE_BITS-1:0] in_sample,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [SAMPLE_BITS-1:0] out_sample,
	input wire logic                          frame_end
);

	logic unused_ok;
	assign unused_ok = ^{cfg_data, in_sample};

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(frame_end))
		else $error("result changed while stalled");

	// every accepted sample leads to an offered result after the read and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("no result two cycles after input transaction");

	// position reduction blocks input right after a ring length write
	a_len_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == fadl_pkg::CFG_RING_LEN |=> !in_ready)
		else $error("input taken during position reduction");

endmodule

bind fractional_audio_delay_line fadl_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_fadl_checker (.*);
`default_nettype wire
